/* hdl/ppf_pkg.sv */
// Package for the ping-pong RGB fade: widths, codes, state types and reset values.
`timescale 1ns / 1ps
`default_nettype none
package ppf_pkg;

    localparam int LED_W      = 6;
    localparam int LEVEL_W    = 12;
    localparam int STEP_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // |end - begin| * step fits in PROD_W bits
    localparam int PROD_W     = LEVEL_W + STEP_W;
    // quotient bits kept; anything at or above 2**QUO_W saturates a level
    localparam int QUO_W      = LEVEL_W + 1;
    // multiplier consumes two bits of |end - begin| per cycle
    localparam int MUL_DIGITS = (LEVEL_W + 1) / 2;
    localparam int CNT_W      = 4;

    localparam logic [CNT_W-1:0]   MUL_LAST  = CNT_W'(MUL_DIGITS - 1);
    localparam logic [CNT_W-1:0]   DIV_LAST  = CNT_W'(QUO_W - 1);
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

    localparam logic [LEVEL_W-1:0] RST_BEGIN_RED   = LEVEL_W'(100);
    localparam logic [LEVEL_W-1:0] RST_BEGIN_GREEN = LEVEL_W'(0);
    localparam logic [LEVEL_W-1:0] RST_BEGIN_BLUE  = LEVEL_W'(0);
    localparam logic [LEVEL_W-1:0] RST_END_RED     = LEVEL_W'(0);
    localparam logic [LEVEL_W-1:0] RST_END_GREEN   = LEVEL_W'(0);
    localparam logic [LEVEL_W-1:0] RST_END_BLUE    = LEVEL_W'(100);
    localparam logic [STEP_W-1:0]  RST_STEP_COUNT  = STEP_W'(100);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BEGIN_RED   = 3'd0,
        CFG_BEGIN_GREEN = 3'd1,
        CFG_BEGIN_BLUE  = 3'd2,
        CFG_END_RED     = 3'd3,
        CFG_END_GREEN   = 3'd4,
        CFG_END_BLUE    = 3'd5,
        CFG_STEP_COUNT  = 3'd6
    } t_cfg_idx;

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } t_state;

    typedef enum logic [2:0] {
        CH_IDLE,
        CH_MUL,
        CH_CHK,
        CH_DIV,
        CH_FIN,
        CH_DONE
    } t_chan_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic chk;
        logic div;
        logic fin;
    } t_chan_ctl;

endpackage
`default_nettype wire

/* hdl/ping_pong_rgb_fade.sv */
// Top level of the ping-pong RGB fade: config registers, step counter, control, result register.
// One tick at a time: the input stalls from a transfer until its result moves to the result register.
// Each tick runs the per-channel serial datapath, 6 radix-4 multiply steps plus
//   13 restoring divide steps, all three channels in parallel.
// A finished result waits in its own register, so the next tick starts while it is unclaimed.
// Reset (synchronous, active low): registers take their default colors and step count,
//   step counter at 0 going up, no result pending.
`timescale 1ns / 1ps
`default_nettype none
module ping_pong_rgb_fade (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration write port
    input  wire logic                           i_cfg_we,
    input  wire logic [ppf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ppf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // tick input
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [ppf_pkg::LED_W-1:0]      i_led_index,
    input  wire logic                           i_restart,
    // result output
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [ppf_pkg::LED_W-1:0]           o_out_led,
    output logic [ppf_pkg::LEVEL_W-1:0]         o_red_level,
    output logic [ppf_pkg::LEVEL_W-1:0]         o_green_level,
    output logic [ppf_pkg::LEVEL_W-1:0]         o_blue_level
);

    localparam int L = ppf_pkg::LEVEL_W;
    localparam int S = ppf_pkg::STEP_W;

    // configuration
    logic [L-1:0] r_begin_red, r_begin_green, r_begin_blue;
    logic [L-1:0] r_end_red, r_end_green, r_end_blue;
    logic [S-1:0] r_step_count;

    // shared fade position
    logic [S-1:0] r_pos, n_pos;
    logic         r_up, n_up;

    ppf_pkg::t_state r_state, n_state;

    logic [ppf_pkg::LED_W-1:0] r_led;
    logic                      r_out_valid;
    logic [ppf_pkg::LED_W-1:0] r_out_led;
    logic [L-1:0]              r_out_red, r_out_green, r_out_blue;

    logic         w_accept;
    logic         w_load_out;
    logic         w_all_done;
    logic [S-1:0] w_pos_eff;
    logic         w_up_eff;
    logic [S:0]   w_inc;
    logic         w_done_r, w_done_g, w_done_b;
    logic [L-1:0] w_lvl_r, w_lvl_g, w_lvl_b;

    // register writes; indices past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_begin_red   <= ppf_pkg::RST_BEGIN_RED;
            r_begin_green <= ppf_pkg::RST_BEGIN_GREEN;
            r_begin_blue  <= ppf_pkg::RST_BEGIN_BLUE;
            r_end_red     <= ppf_pkg::RST_END_RED;
            r_end_green   <= ppf_pkg::RST_END_GREEN;
            r_end_blue    <= ppf_pkg::RST_END_BLUE;
            r_step_count  <= ppf_pkg::RST_STEP_COUNT;
        end else if (i_cfg_we) begin
            case (ppf_pkg::t_cfg_idx'(i_cfg_index))
                ppf_pkg::CFG_BEGIN_RED:   r_begin_red   <= i_cfg_data[L-1:0];
                ppf_pkg::CFG_BEGIN_GREEN: r_begin_green <= i_cfg_data[L-1:0];
                ppf_pkg::CFG_BEGIN_BLUE:  r_begin_blue  <= i_cfg_data[L-1:0];
                ppf_pkg::CFG_END_RED:     r_end_red     <= i_cfg_data[L-1:0];
                ppf_pkg::CFG_END_GREEN:   r_end_green   <= i_cfg_data[L-1:0];
                ppf_pkg::CFG_END_BLUE:    r_end_blue    <= i_cfg_data[L-1:0];
                ppf_pkg::CFG_STEP_COUNT:  r_step_count  <= i_cfg_data[S-1:0];
                default: ;
            endcase
        end
    end

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_all_done = w_done_r && w_done_g && w_done_b;

    // restart applies before this tick's color is computed
    assign w_pos_eff = i_restart ? '0 : r_pos;
    assign w_up_eff  = i_restart | r_up;
    assign w_inc     = {1'b0, w_pos_eff} + 1'b1;

    // ping-pong update: clamp at step_count and turn; at zero turn without moving
    always_comb begin
        n_pos = w_pos_eff;
        n_up  = w_up_eff;
        if (w_up_eff) begin
            if (w_inc > {1'b0, r_step_count}) begin
                n_pos = r_step_count;
                n_up  = 1'b0;
            end else begin
                n_pos = w_inc[S-1:0];
            end
        end else if (w_pos_eff == '0) begin
            n_up = 1'b1;
        end else begin
            n_pos = w_pos_eff - 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ppf_pkg::ST_IDLE: if (w_accept) n_state = ppf_pkg::ST_BUSY;
            ppf_pkg::ST_BUSY: if (w_load_out) n_state = ppf_pkg::ST_IDLE;
            default:          n_state = ppf_pkg::ST_IDLE;
        endcase
    end

    // control outputs; the result moves out once the result register is free
    always_comb begin
        o_in_stall = 1'b1;
        w_load_out = 1'b0;
        case (r_state)
            ppf_pkg::ST_IDLE: o_in_stall = 1'b0;
            ppf_pkg::ST_BUSY: w_load_out = w_all_done && (!r_out_valid || !i_out_stall);
            default:          o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ppf_pkg::ST_IDLE;
            r_pos       <= '0;
            r_up        <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_pos <= n_pos;
                r_up  <= n_up;
            end
            if (w_load_out) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) r_led <= i_led_index;
        if (w_load_out) begin
            r_out_led   <= r_led;
            r_out_red   <= w_lvl_r;
            r_out_green <= w_lvl_g;
            r_out_blue  <= w_lvl_b;
        end
    end

    ppf_chan u_chan_red (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_begin (r_begin_red),
        .i_end   (r_end_red),
        .i_step  (w_pos_eff),
        .i_den   (r_step_count),
        .o_done  (w_done_r),
        .o_level (w_lvl_r)
    );

    ppf_chan u_chan_green (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_begin (r_begin_green),
        .i_end   (r_end_green),
        .i_step  (w_pos_eff),
        .i_den   (r_step_count),
        .o_done  (w_done_g),
        .o_level (w_lvl_g)
    );

    ppf_chan u_chan_blue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_begin (r_begin_blue),
        .i_end   (r_end_blue),
        .i_step  (w_pos_eff),
        .i_den   (r_step_count),
        .o_done  (w_done_b),
        .o_level (w_lvl_b)
    );

    assign o_out_valid   = r_out_valid;
    assign o_out_led     = r_out_led;
    assign o_red_level   = r_out_red;
    assign o_green_level = r_out_green;
    assign o_blue_level  = r_out_blue;

endmodule
`default_nettype wire

/* hdl/ppf_chan.sv */
// One color channel: serial multiply, restoring divide and saturation.
`timescale 1ns / 1ps
`default_nettype none
module ppf_chan (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [ppf_pkg::LEVEL_W-1:0] i_begin,
    input  wire logic [ppf_pkg::LEVEL_W-1:0] i_end,
    input  wire logic [ppf_pkg::STEP_W-1:0]  i_step,
    input  wire logic [ppf_pkg::STEP_W-1:0]  i_den,
    output logic                             o_done,
    output logic [ppf_pkg::LEVEL_W-1:0]      o_level
);

    localparam int L = ppf_pkg::LEVEL_W;
    localparam int S = ppf_pkg::STEP_W;
    localparam int P = ppf_pkg::PROD_W;
    localparam int Q = ppf_pkg::QUO_W;
    localparam int C = ppf_pkg::CNT_W;
    localparam int HI_W = P - Q;          // dividend bits above the kept quotient
    localparam int SUM_W = Q + 2;         // signed room for begin +/- quotient

    ppf_pkg::t_chan_state r_state, n_state;
    ppf_pkg::t_chan_ctl   w_ctl;

    logic [C-1:0] r_cnt;
    logic [L-1:0] r_mag;
    logic         r_neg;
    logic [P-1:0] r_mcand;
    logic [P-1:0] r_acc;
    logic [S-1:0] r_rem;
    logic [Q-1:0] r_dq;
    logic         r_ovf;
    logic [L-1:0] r_level;

    logic [P-1:0]     w_pp;
    logic [S+1:0]     w_trial;
    logic             w_qbit;
    logic [Q:0]       w_round;
    logic [SUM_W-1:0] w_sub;
    logic [SUM_W-1:0] w_add;
    logic [L-1:0]     w_level;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ppf_pkg::CH_IDLE, ppf_pkg::CH_DONE: begin
                if (i_start) n_state = ppf_pkg::CH_MUL;
            end
            ppf_pkg::CH_MUL: begin
                if (r_cnt == ppf_pkg::MUL_LAST) n_state = ppf_pkg::CH_CHK;
            end
            ppf_pkg::CH_CHK: n_state = ppf_pkg::CH_DIV;
            ppf_pkg::CH_DIV: begin
                if (r_cnt == ppf_pkg::DIV_LAST) n_state = ppf_pkg::CH_FIN;
            end
            ppf_pkg::CH_FIN: n_state = ppf_pkg::CH_DONE;
            default:         n_state = ppf_pkg::CH_IDLE;
        endcase
    end

    // decoded controls
    always_comb begin
        w_ctl = '0;
        case (r_state)
            ppf_pkg::CH_IDLE, ppf_pkg::CH_DONE: w_ctl.load = i_start;
            ppf_pkg::CH_MUL: w_ctl.mul = 1'b1;
            ppf_pkg::CH_CHK: w_ctl.chk = 1'b1;
            ppf_pkg::CH_DIV: w_ctl.div = 1'b1;
            ppf_pkg::CH_FIN: w_ctl.fin = 1'b1;
            default:         w_ctl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppf_pkg::CH_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (w_ctl.load || w_ctl.chk) r_cnt <= '0;
            else if (w_ctl.mul || w_ctl.div) r_cnt <= r_cnt + 1'b1;
        end
    end

    // radix-4 partial product of the current digit of |end - begin|
    always_comb begin
        w_pp = '0;
        if (r_mag[0]) w_pp = w_pp + r_mcand;
        if (r_mag[1]) w_pp = w_pp + {r_mcand[P-2:0], 1'b0};
    end

    // restoring divide step
    assign w_trial = {1'b0, r_rem, r_dq[Q-1]} - {2'b00, i_den};
    assign w_qbit  = ~w_trial[S+1];

    // floor for negative differences: round the magnitude quotient up
    assign w_round = {1'b0, r_dq} + {{Q{1'b0}}, (r_neg && (r_rem != '0))};
    assign w_sub   = {{(SUM_W-L){1'b0}}, i_begin} - {1'b0, w_round};
    assign w_add   = {{(SUM_W-L){1'b0}}, i_begin} + {2'b00, r_dq};

    always_comb begin
        if (i_den == '0) begin
            w_level = i_begin;
        end else if (r_ovf) begin
            w_level = r_neg ? '0 : ppf_pkg::LEVEL_MAX;
        end else if (r_neg) begin
            w_level = w_sub[SUM_W-1] ? '0 : w_sub[L-1:0];
        end else begin
            w_level = (w_add > {{(SUM_W-L){1'b0}}, ppf_pkg::LEVEL_MAX}) ?
                      ppf_pkg::LEVEL_MAX : w_add[L-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.load) begin
            r_neg   <= (i_end < i_begin);
            r_mag   <= (i_end < i_begin) ? (i_begin - i_end) : (i_end - i_begin);
            r_mcand <= {{(P-S){1'b0}}, i_step};
            r_acc   <= '0;
        end
        if (w_ctl.mul) begin
            r_acc   <= r_acc + w_pp;
            r_mcand <= {r_mcand[P-3:0], 2'b00};
            r_mag   <= {2'b00, r_mag[L-1:2]};
        end
        if (w_ctl.chk) begin
            r_ovf <= ({{(S-HI_W){1'b0}}, r_acc[P-1:Q]} >= i_den);
            r_rem <= {{(S-HI_W){1'b0}}, r_acc[P-1:Q]};
            r_dq  <= r_acc[Q-1:0];
        end
        if (w_ctl.div) begin
            r_rem <= w_qbit ? w_trial[S-1:0] : {r_rem[S-2:0], r_dq[Q-1]};
            r_dq  <= {r_dq[Q-2:0], w_qbit};
        end
        if (w_ctl.fin) begin
            r_level <= w_level;
        end
    end

    assign o_done  = (r_state == ppf_pkg::CH_DONE);
    assign o_level = r_level;

endmodule
`default_nettype wire

/* hdl/ppf_checker.sv */
// Port-level checks for the ping-pong RGB fade, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ppf_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           o_in_stall,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_stall,
    input wire logic [ppf_pkg::LED_W-1:0]      o_out_led,
    input wire logic [ppf_pkg::LEVEL_W-1:0]    o_red_level,
    input wire logic [ppf_pkg::LEVEL_W-1:0]    o_green_level,
    input wire logic [ppf_pkg::LEVEL_W-1:0]    o_blue_level
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_led) &&
        $stable(o_red_level) && $stable(o_green_level) && $stable(o_blue_level))
        else $error("stalled result changed");

    // a transfer in is followed by a stalled input
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after transfer");

    // a new result appears only as the busy period ends
    a_result_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall) && !o_in_stall)
        else $error("result appeared outside end of work");

    // leaving the busy period always leaves a result behind
    a_busy_ends_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_stall) |-> o_out_valid)
        else $error("work ended without a result");

endmodule

bind ping_pong_rgb_fade ppf_checker u_ppf_checker (.*);
`default_nettype wire

/* bench/ping_pong_rgb_fade_test.sv */
// Self-checking testbench for the ping-pong RGB fade: directed and random fade ticks.
`timescale 1ns / 1ps
module ping_pong_rgb_fade_test;
    import ppf_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int QUIET_LIMIT   = 2000;   // cycles with no transfer or register write before giving up
    localparam int SHOW_LIMIT    = 10;     // mismatches printed in full
    localparam int RANDOM_PHASES = 17;
    localparam int PHASE_TICKS   = 50;
    localparam int DRAIN_CYCLES  = 30;     // idle wait for stray results before the verdict
    localparam int RED           = 0;
    localparam int GREEN         = 1;
    localparam int BLUE          = 2;

    // index with no register behind it; writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    // DUT connections; all inputs known from time zero
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic [LED_W-1:0]      i_led_index = '0;
    logic                  i_restart   = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [LED_W-1:0]      o_out_led;
    logic [LEVEL_W-1:0]    o_red_level;
    logic [LEVEL_W-1:0]    o_green_level;
    logic [LEVEL_W-1:0]    o_blue_level;

    typedef struct {
        logic [LED_W-1:0]   led;
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } fade_color_t;

    // Predicted colors, oldest first
    fade_color_t pending_colors[$];

    // Shadow of the configuration and the shared step counter
    logic [LEVEL_W-1:0] fade_begin[3] = '{RST_BEGIN_RED, RST_BEGIN_GREEN, RST_BEGIN_BLUE};
    logic [LEVEL_W-1:0] fade_end[3]   = '{RST_END_RED, RST_END_GREEN, RST_END_BLUE};
    logic [STEP_W-1:0]  steps_total   = RST_STEP_COUNT;
    logic [16:0]        fade_pos      = '0;
    logic               fade_up       = 1'b1;

    int  fail_count     = 0;
    int  mismatch_count = 0;
    int  out_hold       = 0;
    int  quiet_cycles   = 0;
    bit  no_wait        = 1'b0;  // set for stretches with no idling on either side

    always #(HALF_PERIOD) i_clk = ~i_clk;

    ping_pong_rgb_fade i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_led_index   (i_led_index),
        .i_restart     (i_restart),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_led     (o_out_led),
        .o_red_level   (o_red_level),
        .o_green_level (o_green_level),
        .o_blue_level  (o_blue_level)
    );

    // begin + floor((end - begin) * pos / steps), clamped to the level range.
    // A zero step count gives a quotient of zero, i.e. the begin level.
    function automatic logic [LEVEL_W-1:0] fade_level(input logic [LEVEL_W-1:0] lvl_from,
                                                      input logic [LEVEL_W-1:0] lvl_to);
        longint span;
        longint prod;
        longint quo;
        longint lvl;
        span = longint'(lvl_to) - longint'(lvl_from);
        prod = span * longint'(fade_pos);
        quo  = 0;
        if (steps_total != 0) begin
            quo = prod / longint'(steps_total);
            // division truncates toward zero; floor needs one less for negatives
            if ((prod % longint'(steps_total)) != 0 && prod < 0)
                quo = quo - 1;
        end
        lvl = longint'(lvl_from) + quo;
        if (lvl < 0)
            lvl = 0;
        if (lvl > longint'(LEVEL_MAX))
            lvl = longint'(LEVEL_MAX);
        return lvl[LEVEL_W-1:0];
    endfunction

    // One accepted tick: restart, compute the color, then move the shared counter.
    task automatic predict_color(input logic [LED_W-1:0] led, input logic restart);
        fade_color_t c;
        if (restart) begin
            fade_pos = '0;
            fade_up  = 1'b1;
        end
        c.led   = led;
        c.red   = fade_level(fade_begin[RED], fade_end[RED]);
        c.green = fade_level(fade_begin[GREEN], fade_end[GREEN]);
        c.blue  = fade_level(fade_begin[BLUE], fade_end[BLUE]);
        pending_colors.push_back(c);
        if (fade_up) begin
            fade_pos = fade_pos + 1'b1;
            // covers a count lowered below the position as well
            if (fade_pos > steps_total) begin
                fade_pos = steps_total;
                fade_up  = 1'b0;
            end
        end else if (fade_pos == 0) begin
            fade_up = 1'b1;
        end else begin
            fade_pos = fade_pos - 1'b1;
        end
    endtask

    // Register write: one cycle with the enable high, then one with it low,
    // so consecutive writes never lower and raise the enable in one step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (t_cfg_idx'(idx))
            CFG_BEGIN_RED:   fade_begin[RED]   = data[LEVEL_W-1:0];
            CFG_BEGIN_GREEN: fade_begin[GREEN] = data[LEVEL_W-1:0];
            CFG_BEGIN_BLUE:  fade_begin[BLUE]  = data[LEVEL_W-1:0];
            CFG_END_RED:     fade_end[RED]     = data[LEVEL_W-1:0];
            CFG_END_GREEN:   fade_end[GREEN]   = data[LEVEL_W-1:0];
            CFG_END_BLUE:    fade_end[BLUE]    = data[LEVEL_W-1:0];
            CFG_STEP_COUNT:  steps_total       = data[STEP_W-1:0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Full setting; upper data bits of the 12-bit registers are random junk
    task automatic set_fade(input logic [LEVEL_W-1:0] br, input logic [LEVEL_W-1:0] bg,
                            input logic [LEVEL_W-1:0] bb, input logic [LEVEL_W-1:0] er,
                            input logic [LEVEL_W-1:0] eg, input logic [LEVEL_W-1:0] eb,
                            input logic [STEP_W-1:0] steps);
        write_reg(CFG_BEGIN_RED,   {4'($urandom), br});
        write_reg(CFG_BEGIN_GREEN, {4'($urandom), bg});
        write_reg(CFG_BEGIN_BLUE,  {4'($urandom), bb});
        write_reg(CFG_END_RED,     {4'($urandom), er});
        write_reg(CFG_END_GREEN,   {4'($urandom), eg});
        write_reg(CFG_END_BLUE,    {4'($urandom), eb});
        write_reg(CFG_STEP_COUNT,  steps);
    endtask

    // One tick transfer. Valid is only lowered when a gap is drawn, so a
    // back-to-back tick keeps valid high across the edge.
    task automatic send_tick(input logic [LED_W-1:0] led, input logic restart);
        int gap;
        gap = no_wait ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_led_index <= led;
        i_restart   <= restart;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_color(led, restart);
    endtask

    // Block is idle once every predicted color has come back (each tick gives one)
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        while (pending_colors.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Colors straight out of reset: red falls from 100, blue rises to 100
    task automatic test_reset_colors();
        send_tick(6'd0, 1'b1);
        send_tick(6'd1, 1'b0);
        send_tick(6'd63, 1'b0);
        wait_quiet();
    endtask

    // Level and step extremes; a one-step fade gives the far end twice,
    // falling channels exercise floor on negative products
    task automatic test_full_swing();
        set_fade(12'd0, 12'd0, 12'd0, 12'd4095, 12'd4095, 12'd4095, 16'd1);
        send_tick(6'd2, 1'b1);
        send_tick(6'd63, 1'b0);
        send_tick(6'd0, 1'b0);
        send_tick(6'd1, 1'b0);
        wait_quiet();
        set_fade(12'd4095, 12'd0, 12'd2048, 12'd0, 12'd4095, 12'd2047, 16'd65535);
        send_tick(6'd42, 1'b1);
        send_tick(6'd21, 1'b0);
        send_tick(6'd63, 1'b0);
        wait_quiet();
    endtask

    // Zero step count: begin levels only, counter still bounces at zero
    task automatic test_zero_steps();
        set_fade(12'd1234, 12'd0, 12'd4095, 12'd4000, 12'd17, 12'd0, 16'd0);
        send_tick(6'd5, 1'b1);
        send_tick(6'd1, 1'b0);
        send_tick(6'd0, 1'b0);
        send_tick(6'd3, 1'b0);
        wait_quiet();
    endtask

    // Count lowered below the current position mid-fade: red and green levels saturate,
    // next upward move clamps back to the count. Unused index is ignored.
    task automatic test_past_count();
        set_fade(12'd0, 12'd4095, 12'd2000, 12'd4095, 12'd0, 12'd3000, 16'd12);
        send_tick(6'd0, 1'b1);
        repeat (5) send_tick(6'd1, 1'b0);
        wait_quiet();
        write_reg(CFG_STEP_COUNT, 16'd3);
        write_reg(CFG_UNUSED_IDX, 16'hFFFF);
        send_tick(6'd1, 1'b0);
        send_tick(6'd0, 1'b0);
        wait_quiet();
    endtask

    function automatic logic [LEVEL_W-1:0] rand_level();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return LEVEL_MAX;
            default: return LEVEL_W'($urandom);
        endcase
    endfunction

    function automatic logic [STEP_W-1:0] rand_steps();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 2)
            return '0;
        if (pick < 4)
            return 16'd1;
        if (pick < 6)
            return '1;
        if (pick < 14)
            return STEP_W'($urandom_range(2, 20));
        if (pick < 17)
            return STEP_W'($urandom_range(21, 300));
        return STEP_W'($urandom);
    endfunction

    // Random settings, mostly short fades so the counter turns often. The
    // counter carries over between phases, so lowered counts also happen here.
    task automatic test_random_fades();
        logic [LED_W-1:0] led;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_quiet();
            set_fade(rand_level(), rand_level(), rand_level(),
                     rand_level(), rand_level(), rand_level(), rand_steps());
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
            no_wait = (phase % 4 == 3);
            for (int n = 0; n < PHASE_TICKS; n++) begin
                // half the ticks use LED 0 or 1, the rest any index
                led = $urandom_range(0, 1) ? LED_W'($urandom_range(0, 1)) : LED_W'($urandom);
                send_tick(led, $urandom_range(0, 15) == 0);
            end
            no_wait = 1'b0;
        end
        wait_quiet();
    endtask

    // Result side: check each transfer against the oldest prediction and
    // draw how long to stall after it
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_hold = 0;
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin : check_result
                fade_color_t want;
                if (pending_colors.size() == 0) begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= SHOW_LIMIT)
                        $display("unexpected result: led %0d rgb %0d %0d %0d",
                                 o_out_led, o_red_level, o_green_level, o_blue_level);
                end else begin
                    want = pending_colors.pop_front();
                    if (o_out_led !== want.led || o_red_level !== want.red ||
                        o_green_level !== want.green || o_blue_level !== want.blue) begin
                        fail_count++;
                        mismatch_count++;
                        if (mismatch_count <= SHOW_LIMIT)
                            $display("mismatch: expected led %0d rgb %0d %0d %0d, got led %0d rgb %0d %0d %0d",
                                     want.led, want.red, want.green, want.blue,
                                     o_out_led, o_red_level, o_green_level, o_blue_level);
                    end
                end
                out_hold = no_wait ? 0 : $urandom_range(0, 8);
            end else if (out_hold != 0) begin
                out_hold--;
            end
            i_out_stall <= (out_hold != 0);
        end
    end

    // Watchdog: too long without any transfer or register write means a hang
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_colors();
        test_full_swing();
        test_zero_steps();
        test_past_count();
        test_random_fades();
        // let any stray result show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_colors.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
hdl/ppf_pkg.sv
hdl/ppf_chan.sv
hdl/ping_pong_rgb_fade.sv
hdl/ppf_checker.sv
bench/ping_pong_rgb_fade_test.sv
